// File: hw/rtl/slrc_pkg.sv
// Shared widths, register indexes, reset values and pipeline types of the light ramp controller.
`default_nettype none

package slrc_pkg;

    localparam int TOD_W      = 17;  // time of day and sunrise/sunset, seconds
    localparam int RAMP_W     = 15;  // ramp length, seconds
    localparam int RATE_W     = 24;  // Q8.16 levels per second
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int T10_W      = 23;  // signed time in tenths of a second
    localparam int ELAPSED_W  = 19;  // tenths elapsed inside a ramp, at most ten ramp lengths
    localparam int FRAC_W     = 16;  // fraction bits of the rates

    localparam logic [CFG_IDX_W-1:0] CFG_SUNRISE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUNSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_RATE  = 3'd5;

    localparam logic [TOD_W-1:0]  RST_SUNRISE    = 17'd25200;
    localparam logic [TOD_W-1:0]  RST_SUNSET     = 17'd72000;
    localparam logic [RAMP_W-1:0] RST_RAMP_LEN   = 15'd5400;
    localparam logic [RATE_W-1:0] RST_RED_RATE   = 24'd49700;
    localparam logic [RATE_W-1:0] RST_GREEN_RATE = 24'd62125;
    localparam logic [RATE_W-1:0] RST_BLUE_RATE  = 24'd82833;

    // Load enables of the arithmetic stages.
    typedef struct packed {
        logic load_s2;
        logic load_s3;
        logic load_s4;
    } t_stage_en;

    // Window decisions that travel alongside the levels.
    typedef struct packed {
        logic day_now;
        logic in_dawn;
        logic in_dusk;
        logic green_go;
        logic blue_go;
    } t_window;

endpackage

`default_nettype wire

// File: hw/rtl/sunrise_light_ramp_controller.sv
// Top level of the sunrise light ramp controller: config, window decode, pipeline and switch state.
`default_nettype none

// Usage:
// Input channel i_valid/o_ready carries one tick with the time of day in seconds.
// Output channel o_valid/i_ready returns one result per tick: day and ramp light
// switches, three color levels and a changed flag, in tick order.
// Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data); write it only
// while no tick is in flight. Writes to unknown indexes are dropped.
// The datapath is a five-register pipeline: input register, window decode,
// elapsed-times-rate multiply, divide-by-ten multiply, result and state register.
// Throughput is one tick per cycle while i_ready is high; each stage loads whenever
// it is empty or its successor moves, so bubbles close up behind a stalled receiver
// and ticks are still taken until all five stages hold a transaction.
// While o_valid is high and i_ready is low the result register and the switch state hold.
// Synchronous reset empties the pipeline, restores the config defaults and
// clears both switches and all levels.

module sunrise_light_ramp_controller
    import slrc_pkg::*;
#(
    parameter int LEVEL_BITS = 12
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [TOD_W-1:0]        i_time_of_day_s,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic                    o_day_light_on,
    output logic                    o_ramp_light_on,
    output logic [LEVEL_BITS-1:0]   o_red_level,
    output logic [LEVEL_BITS-1:0]   o_green_level,
    output logic [LEVEL_BITS-1:0]   o_blue_level,
    output logic                    o_outputs_changed,
    input  wire                     i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

    // Configuration registers.
    logic [TOD_W-1:0]  r_sunrise;
    logic [TOD_W-1:0]  r_sunset;
    logic [RAMP_W-1:0] r_ramp_len;
    logic [RATE_W-1:0] r_red_rate;
    logic [RATE_W-1:0] r_green_rate;
    logic [RATE_W-1:0] r_blue_rate;

    // Pipeline valids and payload.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [TOD_W-1:0] r_t1;
    t_window r_win2, r_win3, r_win4;

    logic w_load1, w_load2, w_load3, w_load4, w_load5;
    t_stage_en w_en;

    // Switch and level state, which is also the result register.
    logic                  r_day, r_ramp, r_chg;
    logic [LEVEL_BITS-1:0] r_red, r_green, r_blue;
    logic                  n_day, n_ramp, n_chg;
    logic [LEVEL_BITS-1:0] n_red, n_green, n_blue;

    // Window decode.
    logic signed [T10_W-1:0] w_t10, w_rise10, w_set10, w_r5, w_r3, w_r1;
    logic signed [T10_W-1:0] w_dawn10, w_on10, w_gst10, w_bst10, w_off10, w_dusk10;
    logic signed [T10_W-1:0] w_red_e, w_green_e, w_blue_e;
    t_window n_win;

    logic [LEVEL_BITS-1:0] w_red_amt, w_green_amt, w_blue_amt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sunrise    <= RST_SUNRISE;
            r_sunset     <= RST_SUNSET;
            r_ramp_len   <= RST_RAMP_LEN;
            r_red_rate   <= RST_RED_RATE;
            r_green_rate <= RST_GREEN_RATE;
            r_blue_rate  <= RST_BLUE_RATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SUNRISE:    r_sunrise    <= i_cfg_data[TOD_W-1:0];
                CFG_SUNSET:     r_sunset     <= i_cfg_data[TOD_W-1:0];
                CFG_RAMP_LEN:   r_ramp_len   <= i_cfg_data[RAMP_W-1:0];
                CFG_RED_RATE:   r_red_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_GREEN_RATE: r_green_rate <= i_cfg_data[RATE_W-1:0];
                CFG_BLUE_RATE:  r_blue_rate  <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage loads when empty or when its successor moves.
    assign w_load5 = !r_v5 || i_ready;
    assign w_load4 = !r_v4 || w_load5;
    assign w_load3 = !r_v3 || w_load4;
    assign w_load2 = !r_v2 || w_load3;
    assign w_load1 = !r_v1 || w_load2;
    assign o_ready = w_load1;

    assign w_en.load_s2 = w_load2;
    assign w_en.load_s3 = w_load3;
    assign w_en.load_s4 = w_load4;

    // Times in tenths of a second; ten is eight plus two, five is four plus one.
    always_comb begin
        w_t10    = (T10_W'(r_t1) << 3) + (T10_W'(r_t1) << 1);
        w_rise10 = (T10_W'(r_sunrise) << 3) + (T10_W'(r_sunrise) << 1);
        w_set10  = (T10_W'(r_sunset) << 3) + (T10_W'(r_sunset) << 1);
        w_r5     = (T10_W'(r_ramp_len) << 2) + T10_W'(r_ramp_len);
        w_r3     = (T10_W'(r_ramp_len) << 1) + T10_W'(r_ramp_len);
        w_r1     = T10_W'(r_ramp_len);
        w_dawn10 = w_rise10 - w_r5;
        w_on10   = w_rise10 + w_r5;
        w_gst10  = w_rise10 - w_r3;
        w_bst10  = w_rise10 - w_r1;
        w_off10  = w_set10 - w_r5;
        w_dusk10 = w_set10 + w_r5;

        n_win.day_now  = (w_t10 > w_on10) && (w_t10 < w_off10);
        n_win.in_dawn  = (w_t10 >= w_dawn10) && (w_t10 <= w_on10);
        // Dawn wins where the two windows overlap.
        n_win.in_dusk  = !n_win.in_dawn && (w_t10 >= w_off10) && (w_t10 <= w_dusk10);
        n_win.green_go = (w_t10 >= w_gst10);
        n_win.blue_go  = (w_t10 >= w_bst10);

        // Only in-range differences are ever used, so the low bits suffice.
        w_red_e   = n_win.in_dawn ? (w_t10 - w_dawn10) : (w_t10 - w_off10);
        w_green_e = n_win.in_dawn ? (w_t10 - w_gst10) : (w_t10 - w_off10);
        w_blue_e  = n_win.in_dawn ? (w_t10 - w_bst10) : (w_t10 - w_off10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_load1) r_v1 <= i_valid;
            if (w_load2) r_v2 <= r_v1;
            if (w_load3) r_v3 <= r_v2;
            if (w_load4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) r_t1   <= i_time_of_day_s;
        if (w_load2) r_win2 <= n_win;
        if (w_load3) r_win3 <= r_win2;
        if (w_load4) r_win4 <= r_win3;
    end

    slrc_channel #(.LEVEL_BITS(LEVEL_BITS)) u_red (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_elapsed (w_red_e[ELAPSED_W-1:0]),
        .i_rate    (r_red_rate),
        .o_amount  (w_red_amt)
    );

    slrc_channel #(.LEVEL_BITS(LEVEL_BITS)) u_green (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_elapsed (w_green_e[ELAPSED_W-1:0]),
        .i_rate    (r_green_rate),
        .o_amount  (w_green_amt)
    );

    slrc_channel #(.LEVEL_BITS(LEVEL_BITS)) u_blue (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_elapsed (w_blue_e[ELAPSED_W-1:0]),
        .i_rate    (r_blue_rate),
        .o_amount  (w_blue_amt)
    );

    // Next switch and level state for the transaction leaving stage four.
    always_comb begin
        n_day   = r_win4.day_now;
        n_ramp  = r_ramp;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        n_chg   = (r_win4.day_now != r_day);
        priority if (r_win4.in_dawn) begin
            n_red = w_red_amt;
            if (r_win4.green_go) n_green = w_green_amt;
            if (r_win4.blue_go)  n_blue  = w_blue_amt;
            n_ramp = 1'b1;
            n_chg  = 1'b1;
        end else if (r_win4.in_dusk) begin
            n_red   = LEVEL_MAX - w_red_amt;
            n_green = LEVEL_MAX - w_green_amt;
            n_blue  = LEVEL_MAX - w_blue_amt;
            n_ramp  = 1'b1;
            n_chg   = 1'b1;
        end else if (r_ramp) begin
            n_ramp = 1'b0;
            n_chg  = 1'b1;
        end else begin
            n_ramp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5    <= 1'b0;
            r_day   <= 1'b0;
            r_ramp  <= 1'b0;
            r_chg   <= 1'b0;
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
        end else begin
            if (w_load5) r_v5 <= r_v4;
            if (w_load5 && r_v4) begin
                r_day   <= n_day;
                r_ramp  <= n_ramp;
                r_chg   <= n_chg;
                r_red   <= n_red;
                r_green <= n_green;
                r_blue  <= n_blue;
            end
        end
    end

    assign o_valid           = r_v5;
    assign o_day_light_on    = r_day;
    assign o_ramp_light_on   = r_ramp;
    assign o_red_level       = r_red;
    assign o_green_level     = r_green;
    assign o_blue_level      = r_blue;
    assign o_outputs_changed = r_chg;

`ifndef SYNTH
    // Input stalls only when every stage is full and the receiver holds off.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_ready))
        else $error("input stalled with room in the pipeline");

    // A tick inside a ramp turns the ramp light on and flags a change.
    a_ramp_sets_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && w_load5 && (r_win4.in_dawn || r_win4.in_dusk))
        |=> (o_ramp_light_on && o_outputs_changed))
        else $error("ramp tick did not set ramp light and changed flag");

    // State moves only when a transaction enters the result register.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v4 && w_load5)
        |=> ($stable(o_red_level) && $stable(o_green_level) && $stable(o_blue_level)
             && $stable(o_day_light_on) && $stable(o_ramp_light_on)))
        else $error("light state changed without a transaction");

    // An unchanged result cannot have the ramp light on.
    a_quiet_means_ramp_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_outputs_changed) |-> !o_ramp_light_on)
        else $error("ramp light on without changed flag");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/slrc_channel.sv
// One color channel: elapsed time times rate, scaled to a saturated level amount.
`default_nettype none

module slrc_channel
    import slrc_pkg::*;
#(
    parameter int LEVEL_BITS = 12
) (
    input  wire                     i_clk,
    input  wire t_stage_en          i_en,
    input  wire  [ELAPSED_W-1:0]    i_elapsed,
    input  wire  [RATE_W-1:0]       i_rate,
    output logic [LEVEL_BITS-1:0]   o_amount
);

    localparam int PROD_W = ELAPSED_W + RATE_W;
    localparam int HI_W   = PROD_W - FRAC_W;
    localparam int QMAX   = 10 * ((1 << LEVEL_BITS) - 1);
    localparam int QW     = $clog2(QMAX + 1);
    localparam int KSH    = QW + 4;
    localparam int MUL    = ((1 << KSH) + 9) / 10;
    localparam int MW     = KSH - 2;
    localparam int P2_W   = QW + MW;

    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [QW-1:0]         r_q;
    logic [LEVEL_BITS-1:0] r_amount;

    logic [PROD_W-1:0] w_prod;
    logic [HI_W-1:0]   w_hi;
    logic [QW-1:0]     n_q;
    logic [P2_W-1:0]   w_prod2;

    // Whole tenths-of-a-level, clamped where the level would pass full scale.
    assign w_prod = r_elapsed * i_rate;
    assign w_hi   = w_prod[PROD_W-1:FRAC_W];
    assign n_q    = (w_hi > HI_W'(QMAX)) ? QW'(QMAX) : w_hi[QW-1:0];

    // Divide by ten through a reciprocal multiply; exact over the clamped range.
    assign w_prod2 = r_q * MW'(MUL);

    always_ff @(posedge i_clk) begin
        if (i_en.load_s2) begin
            r_elapsed <= i_elapsed;
        end
        if (i_en.load_s3) begin
            r_q <= n_q;
        end
        if (i_en.load_s4) begin
            r_amount <= w_prod2[KSH +: LEVEL_BITS];
        end
    end

    assign o_amount = r_amount;

endmodule

`default_nettype wire

// File: sim/tb_sunrise_light_ramp_controller.sv
// Self-checking testbench: random and edge-case ticks against a model of the ramp controller.
module tb_sunrise_light_ramp_controller
    import slrc_pkg::*;
();

    localparam int     LEVEL_BITS      = 12;
    localparam longint LEVEL_MAX       = (1 << LEVEL_BITS) - 1;
    localparam longint RATE_DIV        = 655360;
    localparam longint TOD_MAX         = (1 << TOD_W) - 1;
    localparam longint DAY_LAST_S      = 86399;
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     DRAIN_CYCLES    = 12;
    localparam int     IDLE_PERCENT    = 6;
    localparam int     PHASE_TICKS     = 98;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {
        EDGE_DAWN, EDGE_GREEN, EDGE_BLUE, EDGE_ON, EDGE_OFF, EDGE_DUSK
    } t_edge;

    typedef enum int {
        SET_TYPICAL, SET_EXTREME, SET_MINIMAL, SET_ZERO_RAMP,
        SET_OVERLAP, SET_BEYOND_DAY, SET_ANY
    } t_setting;

    typedef struct packed {
        logic                  day_on;
        logic                  ramp_on;
        logic [LEVEL_BITS-1:0] red;
        logic [LEVEL_BITS-1:0] green;
        logic [LEVEL_BITS-1:0] blue;
        logic                  changed;
    } t_lamp_state;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic [TOD_W-1:0]      i_time_of_day_s = '0;
    logic                  i_ready         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_day_light_on;
    logic                  o_ramp_light_on;
    logic [LEVEL_BITS-1:0] o_red_level;
    logic [LEVEL_BITS-1:0] o_green_level;
    logic [LEVEL_BITS-1:0] o_blue_level;
    logic                  o_outputs_changed;

    sunrise_light_ramp_controller #(
        .LEVEL_BITS(LEVEL_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_time_of_day_s  (i_time_of_day_s),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_day_light_on   (o_day_light_on),
        .o_ramp_light_on  (o_ramp_light_on),
        .o_red_level      (o_red_level),
        .o_green_level    (o_green_level),
        .o_blue_level     (o_blue_level),
        .o_outputs_changed(o_outputs_changed),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // Register copies and lamp state of the model
    logic [TOD_W-1:0]  cfg_sunrise    = RST_SUNRISE;
    logic [TOD_W-1:0]  cfg_sunset     = RST_SUNSET;
    logic [RAMP_W-1:0] cfg_ramp       = RST_RAMP_LEN;
    logic [RATE_W-1:0] cfg_red_rate   = RST_RED_RATE;
    logic [RATE_W-1:0] cfg_green_rate = RST_GREEN_RATE;
    logic [RATE_W-1:0] cfg_blue_rate  = RST_BLUE_RATE;
    logic              day_sw         = 1'b0;
    logic              ramp_sw        = 1'b0;
    longint            red_hold       = 0;
    longint            green_hold     = 0;
    longint            blue_hold      = 0;

    logic [TOD_W-1:0] tick_queue[$];
    t_lamp_state      lamp_expect[$];
    int               pushed_ticks    = 0;
    int               accepted_ticks  = 0;
    int               errors          = 0;
    logic             in_fire         = 1'b0;
    logic             idle_en         = 1'b1;
    int               hold_reqs       = 0;
    int               hold_served     = 0;
    int               hold_left       = 0;
    longint           sweep_s         = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Derived window edges in tenths of a second, signed, never wrapped
    function automatic longint window_edge(input t_edge which);
        longint r;
        longint rise10;
        longint set10;
        r      = longint'(cfg_ramp);
        rise10 = longint'(cfg_sunrise) * 10;
        set10  = longint'(cfg_sunset) * 10;
        case (which)
            EDGE_DAWN:  return rise10 - 5 * r;
            EDGE_GREEN: return rise10 - 3 * r;
            EDGE_BLUE:  return rise10 - r;
            EDGE_ON:    return rise10 + 5 * r;
            EDGE_OFF:   return set10 - 5 * r;
            default:    return set10 + 5 * r;
        endcase
    endfunction

    function automatic longint ramp_rise(input longint elapsed10, input longint rate);
        longint v;
        if (elapsed10 < 0) return 0;
        v = (elapsed10 * rate) / RATE_DIV;
        return (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

    function automatic longint ramp_fall(input longint elapsed10, input longint rate);
        longint v;
        v = LEVEL_MAX - ramp_rise(elapsed10, rate);
        return (v < 0) ? 0 : v;
    endfunction

    // Advance the lamp state by one tick and return the result it produces
    function automatic t_lamp_state predict_tick(input logic [TOD_W-1:0] tod);
        t_lamp_state res;
        longint      t10;
        longint      dawn10;
        longint      green10;
        longint      blue10;
        longint      on10;
        longint      off10;
        longint      dusk10;
        logic        changed;
        logic        day_now;
        t10     = longint'(tod) * 10;
        dawn10  = window_edge(EDGE_DAWN);
        green10 = window_edge(EDGE_GREEN);
        blue10  = window_edge(EDGE_BLUE);
        on10    = window_edge(EDGE_ON);
        off10   = window_edge(EDGE_OFF);
        dusk10  = window_edge(EDGE_DUSK);
        changed = 1'b0;
        day_now = (t10 > on10) && (t10 < off10);
        if (day_now != day_sw) begin
            day_sw  = day_now;
            changed = 1'b1;
        end
        // Dawn takes precedence when both windows hold
        if (t10 >= dawn10 && t10 <= on10) begin
            red_hold = ramp_rise(t10 - dawn10, longint'(cfg_red_rate));
            if (t10 >= green10) green_hold = ramp_rise(t10 - green10, longint'(cfg_green_rate));
            if (t10 >= blue10) blue_hold = ramp_rise(t10 - blue10, longint'(cfg_blue_rate));
            ramp_sw = 1'b1;
            changed = 1'b1;
        end else if (t10 >= off10 && t10 <= dusk10) begin
            red_hold   = ramp_fall(t10 - off10, longint'(cfg_red_rate));
            green_hold = ramp_fall(t10 - off10, longint'(cfg_green_rate));
            blue_hold  = ramp_fall(t10 - off10, longint'(cfg_blue_rate));
            ramp_sw    = 1'b1;
            changed    = 1'b1;
        end else if (ramp_sw) begin
            ramp_sw = 1'b0;
            changed = 1'b1;
        end
        res.day_on  = day_sw;
        res.ramp_on = ramp_sw;
        res.red     = red_hold[LEVEL_BITS-1:0];
        res.green   = green_hold[LEVEL_BITS-1:0];
        res.blue    = blue_hold[LEVEL_BITS-1:0];
        res.changed = changed;
        return res;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SUNRISE:    cfg_sunrise    = data[TOD_W-1:0];
            CFG_SUNSET:     cfg_sunset     = data[TOD_W-1:0];
            CFG_RAMP_LEN:   cfg_ramp       = data[RAMP_W-1:0];
            CFG_RED_RATE:   cfg_red_rate   = data[RATE_W-1:0];
            CFG_GREEN_RATE: cfg_green_rate = data[RATE_W-1:0];
            CFG_BLUE_RATE:  cfg_blue_rate  = data[RATE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void push_tick(input longint t);
        longint c;
        c = clamp_range(t, 0, TOD_MAX);
        tick_queue.push_back(c[TOD_W-1:0]);
        pushed_ticks++;
    endfunction

    // A clock walking through the ramps, plus edge hits, random ramp times and noise
    function automatic longint pick_time();
        int unsigned mode;
        longint      lo;
        longint      hi;
        t_edge       which;
        mode = $urandom_range(99);
        if (mode < 40) begin
            sweep_s += $urandom_range(int'(cfg_ramp) / 16 + 1, 1);
            if (sweep_s > window_edge(EDGE_DUSK) / 10 + 60 || sweep_s > DAY_LAST_S
                    || sweep_s < window_edge(EDGE_DAWN) / 10 - 60) begin
                sweep_s = window_edge(EDGE_DAWN) / 10 - $urandom_range(60);
            end else if (sweep_s > window_edge(EDGE_ON) / 10 + 60
                    && sweep_s < window_edge(EDGE_OFF) / 10 - 60) begin
                sweep_s = window_edge(EDGE_OFF) / 10 - $urandom_range(60);
            end
            sweep_s = clamp_range(sweep_s, 0, TOD_MAX);
            return sweep_s;
        end else if (mode < 65) begin
            which = t_edge'($urandom_range(EDGE_DUSK, EDGE_DAWN));
            return window_edge(which) / 10 + longint'($urandom_range(6)) - 3;
        end else if (mode < 80) begin
            if ($urandom_range(1) == 1) begin
                lo = window_edge(EDGE_DAWN) / 10;
                hi = window_edge(EDGE_ON) / 10;
            end else begin
                lo = window_edge(EDGE_OFF) / 10;
                hi = window_edge(EDGE_DUSK) / 10;
            end
            lo = clamp_range(lo, 0, TOD_MAX);
            hi = clamp_range(hi, lo, TOD_MAX);
            return $urandom_range(int'(hi), int'(lo));
        end else if (mode < 92) begin
            return $urandom_range(int'(DAY_LAST_S), 0);
        end
        return $urandom_range(int'(TOD_MAX), 0);
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_cfg(idx, data);
    endtask

    // Hold until every pushed tick is accepted and every result returned
    task automatic wait_idle();
        do @(negedge i_clk);
        while (!(accepted_ticks == pushed_ticks && lamp_expect.size() == 0));
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input int unsigned sr, input int unsigned ss,
                                input int unsigned rl, input longint rr,
                                input longint gr, input longint br);
        logic [CFG_DATA_W-1:0] pad;
        pad = CFG_DATA_W'($urandom);
        write_reg(CFG_SUNRISE, {pad[CFG_DATA_W-1:TOD_W], sr[TOD_W-1:0]});
        pad = CFG_DATA_W'($urandom);
        write_reg(CFG_SUNSET, {pad[CFG_DATA_W-1:TOD_W], ss[TOD_W-1:0]});
        pad = CFG_DATA_W'($urandom);
        write_reg(CFG_RAMP_LEN, {pad[CFG_DATA_W-1:RAMP_W], rl[RAMP_W-1:0]});
        write_reg(CFG_RED_RATE, rr[RATE_W-1:0]);
        write_reg(CFG_GREEN_RATE, gr[RATE_W-1:0]);
        write_reg(CFG_BLUE_RATE, br[RATE_W-1:0]);
        // Unlisted index: must leave every register alone
        pad = CFG_DATA_W'($urandom);
        write_reg(($urandom_range(1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI, pad);
    endtask

    task automatic apply_setting(input t_setting s);
        int unsigned sr;
        int unsigned ss;
        int unsigned rl;
        longint      rr;
        longint      gr;
        longint      br;
        sr = $urandom_range(int'(DAY_LAST_S), 0);
        ss = $urandom_range(int'(DAY_LAST_S), 0);
        rl = $urandom_range(10800, 600);
        rr = longint'($urandom);
        gr = longint'($urandom);
        br = longint'($urandom);
        case (s)
            SET_TYPICAL: begin
                sr = $urandom_range(32400, 18000);
                ss = $urandom_range(79200, 57600);
                rr = (4095 * 65536) / rl;
                gr = rr * 5 / 4;
                br = rr * 5 / 3;
            end
            SET_EXTREME: begin
                sr = 0;
                ss = 32'(DAY_LAST_S);
                rl = 21600;
                rr = (1 << RATE_W) - 1;
                gr = rr;
                br = rr;
            end
            SET_MINIMAL: begin
                sr = 32'(DAY_LAST_S);
                ss = 0;
                rl = 1;
                rr = 0;
                gr = 0;
                br = 0;
            end
            SET_ZERO_RAMP: rl = 0;
            SET_OVERLAP: begin
                sr = $urandom_range(50000, 30000);
                ss = sr + $urandom_range(3000, 0);
                rl = 21600;
                rr = (4095 * 65536) / rl;
                gr = rr * 5 / 4;
                br = rr * 5 / 3;
            end
            SET_BEYOND_DAY: begin
                sr = $urandom_range(int'(TOD_MAX), int'(DAY_LAST_S) + 1);
                ss = ($urandom_range(1) == 1) ? 32'(TOD_MAX)
                                              : $urandom_range(int'(TOD_MAX), 0);
                rl = (1 << RAMP_W) - 1;
            end
            default: begin
                sr = $urandom_range(int'(TOD_MAX), 0);
                ss = $urandom_range(int'(TOD_MAX), 0);
                rl = $urandom_range((1 << RAMP_W) - 1, 0);
            end
        endcase
        program_regs(sr, ss, rl, rr, gr, br);
    endtask

    // Sender: present a new tick once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_valid || in_fire) begin
            if (tick_queue.size() > 0 && !(idle_en && $urandom_range(99) < IDLE_PERCENT)) begin
                i_valid         <= 1'b1;
                i_time_of_day_s <= tick_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served = hold_reqs;
            hold_left   = HOLD_OFF_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(idle_en && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Predict on each accepted tick, compare each returned transaction
    always @(posedge i_clk) begin : scoreboard
        t_lamp_state want;
        in_fire <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            lamp_expect.push_back(predict_tick(i_time_of_day_s));
            accepted_ticks++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (lamp_expect.size() == 0) begin
                $display("%0t: result with no tick pending, actual %0h", $time,
                         {o_day_light_on, o_ramp_light_on, o_red_level, o_green_level,
                          o_blue_level, o_outputs_changed});
                errors++;
            end else begin
                want = lamp_expect.pop_front();
                check_field("day_light_on", want.day_on, o_day_light_on);
                check_field("ramp_light_on", want.ramp_on, o_ramp_light_on);
                check_field("red_level", want.red, o_red_level);
                check_field("green_level", want.green, o_green_level);
                check_field("blue_level", want.blue, o_blue_level);
                check_field("outputs_changed", want.changed, o_outputs_changed);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        do begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_setting plan[$];
        plan = '{SET_TYPICAL, SET_EXTREME, SET_MINIMAL, SET_ZERO_RAMP, SET_OVERLAP,
                 SET_BEYOND_DAY, SET_ANY, SET_TYPICAL, SET_ANY, SET_OVERLAP, SET_TYPICAL};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, every window edge and its neighbors, field extremes
        for (int e = EDGE_DAWN; e <= EDGE_DUSK; e++) begin
            push_tick(window_edge(t_edge'(e)) / 10 - 1);
            push_tick(window_edge(t_edge'(e)) / 10);
            push_tick(window_edge(t_edge'(e)) / 10 + 1);
        end
        push_tick(0);
        push_tick(DAY_LAST_S);
        push_tick(TOD_MAX);
        push_tick(50000);
        wait_idle();

        foreach (plan[p]) begin
            apply_setting(plan[p]);
            @(posedge i_clk);
            idle_en = (plan[p] != SET_EXTREME);
            // First phase: stall the output while ticks keep coming
            if (p == 0) hold_reqs++;
            repeat ((plan[p] == SET_EXTREME) ? 2 * PHASE_TICKS : PHASE_TICKS)
                push_tick(pick_time());
            wait_idle();
        end

        if (errors == 0 && lamp_expect.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
